// ===== rtl/mfm_dec_pkg.sv =====
// Shared constants, types and bit-gather helpers for the MFM sector decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfm_dec_pkg;

   localparam int DATA_WORDS   = 128;
   localparam int MAX_SECTORS  = 22;
   localparam int LABEL_WORDS  = 4;

   localparam int WORD_W       = 32;
   localparam int HALF_W       = 16;
   localparam int KIND_W       = 3;
   localparam int INDEX_W      = 7;
   localparam int SECT_W       = 5;

   localparam logic [WORD_W-1:0] MFM_MASK = 32'h5555_5555;

   localparam int HDR_FIRST    = 2;
   localparam int LABEL_FIRST  = 4;
   localparam int HSUM_FIRST   = LABEL_FIRST + 2 * LABEL_WORDS;
   localparam int DSUM_FIRST   = HSUM_FIRST + 2;
   localparam int ODD_FIRST    = DSUM_FIRST + 2;
   localparam int EVEN_FIRST   = ODD_FIRST + DATA_WORDS;
   localparam int SECTOR_WORDS = EVEN_FIRST + DATA_WORDS;

   localparam int POS_W        = $clog2(SECTOR_WORDS);
   localparam int IDX_W        = $clog2(DATA_WORDS);

   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_SPT_ADDR = 3'd0;
   localparam logic [SECT_W-1:0]     SPT_RESET    = 5'd11;

   typedef enum logic [KIND_W-1:0] {
      KIND_FORMAT = 3'd0,
      KIND_LABEL  = 3'd1,
      KIND_HSUM   = 3'd2,
      KIND_DSUM   = 3'd3,
      KIND_DATA   = 3'd4
   } kind_type;

   function automatic logic [HALF_W-1:0] pack_bits(input logic [WORD_W-1:0] v);
      logic [HALF_W-1:0] r;
      for (int i = 0; i < HALF_W; i++) begin
         r[i] = v[2*i];
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] spread_bits(input logic [HALF_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int i = 0; i < HALF_W; i++) begin
         r[2*i] = v[i];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/mfm_dec_if.sv =====
// Valid/ready channel interfaces for raw longwords in and decoded words out.
// Depends on mfm_dec_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface mfm_dec_req_if;
   logic                            valid;
   logic                            ready;
   logic [mfm_dec_pkg::WORD_W-1:0]  encoded_word;

   modport source (output valid, output encoded_word, input ready);
   modport sink   (input valid, input encoded_word, output ready);
endinterface

interface mfm_dec_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [mfm_dec_pkg::WORD_W-1:0]  decoded_word;
   mfm_dec_pkg::kind_type           word_kind;
   logic [mfm_dec_pkg::INDEX_W-1:0] word_index;
   logic [mfm_dec_pkg::SECT_W-1:0]  sector_count;
   logic [mfm_dec_pkg::WORD_W-1:0]  computed_checksum;
   logic                            sector_last;
   logic                            track_last;

   modport source (output valid, output decoded_word, output word_kind, output word_index,
                   output sector_count, output computed_checksum, output sector_last,
                   output track_last, input ready);
   modport sink   (input valid, input decoded_word, input word_kind, input word_index,
                   input sector_count, input computed_checksum, input sector_last,
                   input track_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfm_dec_csr.sv =====
// APB-style register port holding the sectors-per-track count.
// Depends on mfm_dec_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfm_dec_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [mfm_dec_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mfm_dec_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mfm_dec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                     pready,
   output logic      [mfm_dec_pkg::SECT_W-1:0]      spt_eff
);
   import mfm_dec_pkg::*;

   logic [SECT_W-1:0] spt_ff;
   logic [SECT_W-1:0] spt_in;
   logic              wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr == CSR_SPT_ADDR);
   assign spt_in = wr_hit ? pwdata[SECT_W-1:0] : spt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff <= SPT_RESET;
      end else begin
         spt_ff <= spt_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_SPT_ADDR) begin
         prdata = CSR_DATA_W'(spt_ff);
      end
   end

   // zero reads as one sector, large values clamp
   always_comb begin
      if (spt_ff == '0) begin
         spt_eff = SECT_W'(1);
      end else if (32'(spt_ff) > MAX_SECTORS) begin
         spt_eff = SECT_W'(MAX_SECTORS);
      end else begin
         spt_eff = spt_ff;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mfm_dec_core.sv =====
// Track position sequencer, odd-half store and decode pipeline.
// Depends on mfm_dec_pkg and mfm_dec_if.
`timescale 1ns / 1ps
`default_nettype none
module mfm_dec_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [mfm_dec_pkg::SECT_W-1:0]  spt_eff,
   mfm_dec_req_if.sink                          req_bus,
   mfm_dec_rsp_if.source                        rsp_bus
);
   import mfm_dec_pkg::*;

   logic [HALF_W-1:0] odd_mem [DATA_WORDS];
   logic [HALF_W-1:0] rdata_ff;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [SECT_W-1:0] sect_ff, sect_in;
   logic [WORD_W-1:0] hsum_ff, hsum_in;
   logic [WORD_W-1:0] dsum_ff, dsum_in;
   logic [HALF_W-1:0] pend_ff;

   // stage 1: waiting for store read data
   logic              s1_valid_ff;
   logic              s1_mem_ff;
   logic [HALF_W-1:0] s1_first_ff;
   logic [WORD_W-1:0] s1_m_ff;
   kind_type          s1_kind_ff;
   logic [INDEX_W-1:0] s1_idx_ff;
   logic [SECT_W-1:0] s1_sect_ff;
   logic [WORD_W-1:0] s1_sum_ff;
   logic              s1_slast_ff;
   logic              s1_tlast_ff;

   // output register
   logic              out_valid_ff;
   logic [WORD_W-1:0] out_word_ff;
   kind_type          out_kind_ff;
   logic [INDEX_W-1:0] out_idx_ff;
   logic [SECT_W-1:0] out_sect_ff;
   logic [WORD_W-1:0] out_sum_ff;
   logic              out_slast_ff;
   logic              out_tlast_ff;

   logic              out_free, s1_move, accept;
   logic [WORD_W-1:0] m;
   logic [WORD_W-1:0] hsum_base, dsum_base;
   logic              is_hdr, is_odd, is_even, first_half, emit;
   logic [POS_W-1:0]  odd_off, even_off;
   logic [IDX_W-1:0]  odd_addr, even_addr;
   logic              data_last, sect_wrap;
   logic [SECT_W:0]   sect_next;
   kind_type          kind;
   logic [INDEX_W-1:0] idx;
   logic [WORD_W-1:0] sum;
   logic [HALF_W-1:0] s1_half;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign req_bus.ready = !s1_valid_ff || out_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign m          = req_bus.encoded_word & MFM_MASK;
   assign is_hdr     = pos_ff >= POS_W'(HDR_FIRST) && pos_ff < POS_W'(ODD_FIRST);
   assign is_odd     = pos_ff >= POS_W'(ODD_FIRST) && pos_ff < POS_W'(EVEN_FIRST);
   assign is_even    = pos_ff >= POS_W'(EVEN_FIRST);
   assign first_half = !pos_ff[0];
   assign emit       = (is_hdr && !first_half) || is_even;
   assign odd_off    = pos_ff - POS_W'(ODD_FIRST);
   assign even_off   = pos_ff - POS_W'(EVEN_FIRST);
   assign odd_addr   = odd_off[IDX_W-1:0];
   assign even_addr  = even_off[IDX_W-1:0];
   assign data_last  = is_even && (even_addr == IDX_W'(DATA_WORDS - 1));
   assign sect_next  = {1'b0, sect_ff} + (SECT_W+1)'(1);
   assign sect_wrap  = sect_next >= {1'b0, spt_eff};

   assign hsum_base = (pos_ff == '0) ? '0 : hsum_ff;
   assign dsum_base = (pos_ff == '0) ? '0 : dsum_ff;
   assign hsum_in   = (is_hdr && pos_ff < POS_W'(HSUM_FIRST)) ? (hsum_base ^ m) : hsum_base;
   assign dsum_in   = (is_odd || is_even) ? (dsum_base ^ m) : dsum_base;

   always_comb begin
      kind = KIND_DATA;
      idx  = INDEX_W'(even_addr);
      sum  = data_last ? dsum_in : '0;
      if (is_hdr) begin
         idx = '0;
         sum = '0;
         if (pos_ff < POS_W'(LABEL_FIRST)) begin
            kind = KIND_FORMAT;
         end else if (pos_ff < POS_W'(HSUM_FIRST)) begin
            kind = KIND_LABEL;
            idx  = INDEX_W'((pos_ff - POS_W'(LABEL_FIRST)) >> 1);
         end else if (pos_ff < POS_W'(DSUM_FIRST)) begin
            kind = KIND_HSUM;
            sum  = hsum_ff;
         end else begin
            kind = KIND_DSUM;
         end
      end
   end

   always_comb begin
      pos_in  = pos_ff + POS_W'(1);
      sect_in = sect_ff;
      if (pos_ff == POS_W'(SECTOR_WORDS - 1)) begin
         pos_in  = '0;
         sect_in = sect_wrap ? '0 : sect_next[SECT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_odd) begin
         odd_mem[odd_addr] <= pack_bits(m);
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_even) begin
         rdata_ff <= odd_mem[even_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sect_ff      <= '0;
         hsum_ff      <= '0;
         dsum_ff      <= '0;
         pend_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pos_ff  <= pos_in;
            sect_ff <= sect_in;
            hsum_ff <= hsum_in;
            dsum_ff <= dsum_in;
            if (is_hdr && first_half) begin
               pend_ff <= pack_bits(m);
            end
            s1_valid_ff <= emit;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mem_ff   <= is_even;
         s1_first_ff <= pend_ff;
         s1_m_ff     <= m;
         s1_kind_ff  <= kind;
         s1_idx_ff   <= idx;
         s1_sect_ff  <= sect_ff;
         s1_sum_ff   <= sum;
         s1_slast_ff <= data_last;
         s1_tlast_ff <= data_last && sect_wrap;
      end
   end

   assign s1_half = s1_mem_ff ? rdata_ff : s1_first_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         out_word_ff  <= (spread_bits(s1_half) << 1) | s1_m_ff;
         out_kind_ff  <= s1_kind_ff;
         out_idx_ff   <= s1_idx_ff;
         out_sect_ff  <= s1_sect_ff;
         out_sum_ff   <= s1_sum_ff;
         out_slast_ff <= s1_slast_ff;
         out_tlast_ff <= s1_tlast_ff;
      end
   end

   assign rsp_bus.valid             = out_valid_ff;
   assign rsp_bus.decoded_word      = out_word_ff;
   assign rsp_bus.word_kind         = out_kind_ff;
   assign rsp_bus.word_index        = out_idx_ff;
   assign rsp_bus.sector_count      = out_sect_ff;
   assign rsp_bus.computed_checksum = out_sum_ff;
   assign rsp_bus.sector_last       = out_slast_ff;
   assign rsp_bus.track_last        = out_tlast_ff;

endmodule
`default_nettype wire

// ===== rtl/mfm_track_sector_decoder_top.sv =====
// Top level of the MFM track sector decoder: register port and decode core.
// Depends on mfm_dec_pkg, mfm_dec_if, mfm_dec_csr and mfm_dec_core.
`timescale 1ns / 1ps
`default_nettype none
// Takes one raw MFM longword per cycle while results are taken, gapless from the
// start of a track, and delivers decoded header fields and data words via the stage-1
// and output registers after the transfer that completes them. Odd halves of the
// data area go to a 128 x 16 store with a registered read; each even half reads
// its partner back as it is taken. Sync words, first halves and odd data halves
// give no output. Computed XOR checksums are reported but not compared. Write
// sectors_per_track (address 0) only while idle.
module mfm_track_sector_decoder_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mfm_dec_req_if.sink                              req_bus,
   mfm_dec_rsp_if.source                            rsp_bus,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [mfm_dec_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [mfm_dec_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [mfm_dec_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                     pready
);
   import mfm_dec_pkg::*;

   logic [SECT_W-1:0] spt_eff;

   mfm_dec_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .spt_eff (spt_eff)
   );

   mfm_dec_core u_core (
      .clock   (clock),
      .reset   (reset),
      .spt_eff (spt_eff),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

// ===== sim/mfm_dec_checker.sv =====
// Scoreboard for the MFM sector decoder: watches both channels and the register port,
// predicts each decoded word from the raw stream and compares field by field.
// Depends on mfm_dec_pkg and mfm_dec_if.
`timescale 1ns / 1ps
module mfm_dec_checker import mfm_dec_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   mfm_dec_req_if                     req_mon,
   mfm_dec_rsp_if                     rsp_mon,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic                  pready,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output int                         outstanding,
   output int                         mismatches
);

   localparam int PRINT_CAP = 200;

   typedef struct {
      logic [WORD_W-1:0]  word;
      kind_type           kind;
      logic [INDEX_W-1:0] index;
      logic [SECT_W-1:0]  sector;
      logic [WORD_W-1:0]  csum;
      logic               sector_end;
      logic               track_end;
   } decoded_t;

   decoded_t          decoded_q[$];
   logic [HALF_W-1:0] odd_halves[DATA_WORDS];
   logic [HALF_W-1:0] first_half;
   logic [WORD_W-1:0] hdr_sum;
   logic [WORD_W-1:0] dat_sum;
   logic [SECT_W-1:0] spt_reg;
   int                word_pos;
   int                cur_sector;
   int                fail_tally = 0;

   function automatic logic [HALF_W-1:0] odd_bits_of(input logic [WORD_W-1:0] v);
      logic [HALF_W-1:0] r;
      logic [WORD_W-1:0] t;
      t = v;
      for (int b = 0; b < HALF_W; b++) begin
         r[b] = t[0];
         t = t >> 2;
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] interleave(input logic [HALF_W-1:0] v);
      logic [WORD_W-1:0] r;
      r = '0;
      for (int b = HALF_W - 1; b >= 0; b--) begin
         r = (r << 2) | WORD_W'(v[b]);
      end
      return r;
   endfunction

   function automatic int sectors_in_track();
      if (spt_reg == 0) return 1;
      if (spt_reg > MAX_SECTORS) return MAX_SECTORS;
      return int'(spt_reg);
   endfunction

   task automatic report(input string what);
      fail_tally++;
      if (fail_tally <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
   endtask

   task automatic predict_word(input logic [WORD_W-1:0] raw);
      logic [WORD_W-1:0] m;
      decoded_t          d;
      int                i;
      bit                gives;
      m = raw & MFM_MASK;
      gives = 0;
      d.word = '0;
      d.kind = KIND_FORMAT;
      d.index = '0;
      d.sector = SECT_W'(cur_sector);
      d.csum = '0;
      d.sector_end = 1'b0;
      d.track_end = 1'b0;
      if (word_pos == 0) begin
         hdr_sum = '0;
         dat_sum = '0;
      end
      if (word_pos >= HDR_FIRST && word_pos < ODD_FIRST) begin
         if (word_pos < HSUM_FIRST) hdr_sum ^= m;
         if (word_pos % 2 == 0) begin
            first_half = odd_bits_of(m);
         end else begin
            gives = 1;
            d.word = (interleave(first_half) << 1) | m;
            if (word_pos < LABEL_FIRST) begin
               d.kind = KIND_FORMAT;
            end else if (word_pos < HSUM_FIRST) begin
               d.kind = KIND_LABEL;
               d.index = INDEX_W'((word_pos - LABEL_FIRST) / 2);
            end else if (word_pos < DSUM_FIRST) begin
               d.kind = KIND_HSUM;
               d.csum = hdr_sum;
            end else begin
               d.kind = KIND_DSUM;
            end
         end
      end else if (word_pos >= ODD_FIRST && word_pos < EVEN_FIRST) begin
         odd_halves[word_pos - ODD_FIRST] = odd_bits_of(m);
         dat_sum ^= m;
      end else if (word_pos >= EVEN_FIRST) begin
         i = word_pos - EVEN_FIRST;
         dat_sum ^= m;
         gives = 1;
         d.word = (interleave(odd_halves[i]) << 1) | m;
         d.kind = KIND_DATA;
         d.index = INDEX_W'(i);
         d.sector_end = (i == DATA_WORDS - 1);
         d.csum = d.sector_end ? dat_sum : '0;
         d.track_end = d.sector_end && (cur_sector + 1 >= sectors_in_track());
      end
      if (gives) decoded_q.push_back(d);
      word_pos++;
      if (word_pos >= SECTOR_WORDS) begin
         word_pos = 0;
         cur_sector++;
         if (cur_sector >= sectors_in_track()) cur_sector = 0;
      end
   endtask

   task automatic check_result();
      decoded_t d;
      if (decoded_q.size() == 0) begin
         report($sformatf("result with nothing expected, word %h", rsp_mon.decoded_word));
      end else begin
         d = decoded_q.pop_front();
         if (rsp_mon.decoded_word !== d.word)
            report($sformatf("decoded_word %h, want %h", rsp_mon.decoded_word, d.word));
         if (rsp_mon.word_kind !== d.kind)
            report($sformatf("word_kind %0d, want %0d", rsp_mon.word_kind, d.kind));
         if (rsp_mon.word_index !== d.index)
            report($sformatf("word_index %0d, want %0d", rsp_mon.word_index, d.index));
         if (rsp_mon.sector_count !== d.sector)
            report($sformatf("sector_count %0d, want %0d", rsp_mon.sector_count, d.sector));
         if (rsp_mon.computed_checksum !== d.csum)
            report($sformatf("computed_checksum %h, want %h",
                             rsp_mon.computed_checksum, d.csum));
         if (rsp_mon.sector_last !== d.sector_end)
            report($sformatf("sector_last %b, want %b", rsp_mon.sector_last, d.sector_end));
         if (rsp_mon.track_last !== d.track_end)
            report($sformatf("track_last %b, want %b", rsp_mon.track_last, d.track_end));
      end
   endtask

   // pop before push: a result can never belong to a word taken at the same edge
   always @(posedge clock) begin
      if (reset) begin
         decoded_q.delete();
         foreach (odd_halves[k]) odd_halves[k] = '0;
         first_half = '0;
         hdr_sum = '0;
         dat_sum = '0;
         word_pos = 0;
         cur_sector = 0;
         spt_reg = SPT_RESET;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_result();
         if (req_mon.valid && req_mon.ready) predict_word(req_mon.encoded_word);
         if (psel && penable && pwrite && pready && paddr == CSR_SPT_ADDR)
            spt_reg = pwdata[SECT_W-1:0];
      end
      outstanding <= decoded_q.size();
      mismatches <= fail_tally;
   end

endmodule

// ===== sim/mfm_track_sector_decoder_top_test.sv =====
// Testbench top for the MFM track sector decoder: clock, reset, raw word stream,
// result back-pressure and sectors_per_track writes; verdict from mfm_dec_checker.
// Depends on mfm_dec_pkg, mfm_dec_if, mfm_dec_checker and the decoder RTL.
`timescale 1ns / 1ps
module mfm_track_sector_decoder_top_test;
   import mfm_dec_pkg::*;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int DRAIN_SLACK = 8;
   localparam int HOLD_AT     = 300;
   localparam int HOLD_CYCLES = 400;
   localparam int OPENING_N   = 24;

   // first words of the track: sync, header pairs with extreme patterns, odd halves
   localparam logic [WORD_W-1:0] OPENING_WORDS [OPENING_N] = '{
      32'h4489_4489, 32'h4489_4489,
      32'hFFFF_FFFF, 32'h0000_0000,
      32'h0000_0000, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'h0000_0000, 32'h0000_0000,
      32'hAAAA_AAAA, 32'h5555_5555,
      32'h5555_5555, 32'hAAAA_AAAA,
      32'h1234_5678, 32'h9ABC_DEF0,
      32'hFFFF_FFFF, 32'h0000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h8000_0001, 32'h7FFF_FFFE, 32'hDEAD_BEEF, 32'h0123_4567
   };

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    outstanding;
   int                    mismatches;
   int                    cycles = 0;
   int                    stream_idx = 0;
   int                    send_run_left = 0;
   bit                    send_eager = 0;

   mfm_dec_req_if req_bus();
   mfm_dec_rsp_if rsp_bus();

   mfm_track_sector_decoder_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   mfm_dec_checker decode_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_word(input logic [WORD_W-1:0] w);
      int gap;
      if (send_run_left == 0) begin
         send_run_left = $urandom_range(16, 96);
         send_eager = ($urandom_range(0, 3) == 0);
      end
      send_run_left--;
      gap = send_eager ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.encoded_word <= w;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic run_words(input int n);
      logic [WORD_W-1:0] w;
      for (int k = 0; k < n; k++) begin
         if (stream_idx < OPENING_N) begin
            w = OPENING_WORDS[stream_idx];
         end else begin
            case ($urandom_range(0, 9))
               0: w = '0;
               1: w = '1;
               2: w = MFM_MASK;
               3: w = ~MFM_MASK;
               default: w = $urandom();
            endcase
         end
         stream_idx++;
         push_word(w);
      end
      req_bus.valid <= 1'b0;
   endtask

   // wait for every expected transfer, then give the pipeline time to empty
   task automatic settle();
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_spt(input logic [SECT_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_SPT_ADDR;
      pwdata <= ($urandom() & ~32'h1F) | CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // result side: random stalls, eager stretches, one long hold-off
   initial begin
      int  stall;
      int  taken;
      int  run_left;
      bit  eager;
      taken = 0;
      run_left = 0;
      eager = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (run_left == 0) begin
            run_left = $urandom_range(16, 96);
            eager = ($urandom_range(0, 3) == 0);
         end
         run_left--;
         stall = eager ? 0 : $urandom_range(0, 17);
         if (taken == HOLD_AT) stall = HOLD_CYCLES;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         taken++;
      end
   end

   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.encoded_word <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset count of 11: first sector, then into the odd area of the second
      run_words(300);
      settle();
      // zero acts as one; sector 1 is past the count and wraps at its end
      write_spt(5'd0);
      run_words(244);
      settle();
      // saturates to the maximum; stop part-way through the even halves
      write_spt(5'd31);
      run_words(200);
      settle();
      write_spt(5'd2);
      run_words(344);
      settle();
      write_spt(5'd22);
      run_words(150);
      settle();
      write_spt(5'd1);
      run_words(122);
      settle();

      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== mfm_track_sector_decoder_top.f =====
rtl/mfm_dec_pkg.sv
rtl/mfm_dec_if.sv
rtl/mfm_dec_csr.sv
rtl/mfm_dec_core.sv
rtl/mfm_track_sector_decoder_top.sv
sim/mfm_dec_checker.sv
sim/mfm_track_sector_decoder_top_test.sv
